### src/uer_pkg.sv
// Shared types, constants and the control store for the ultrasonic echo ranger.
// Used by ultrasonic_echo_ranger, uer_checker and the bench tb; depends on nothing else.
package uer_pkg;

  // Limits and field widths
  localparam int MAX_PINGS   = 8;
  localparam int TRIG_W      = 10;
  localparam int TIMEOUT_W   = 16;
  localparam int SETTLE_W    = 16;
  localparam int COUNT_W     = 4;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int TICK_W      = 16;
  localparam int TOTAL_W     = 20;
  localparam int PING_W      = $clog2(MAX_PINGS + 1);
  localparam int ERR_W       = 2;
  localparam int DIST_W      = 14;

  // Distance scaling: eighth-cm = width * 8 / 58, rounded half up
  localparam int SCALE_SHIFT = 3;
  localparam int CM_TICKS    = 58;
  localparam int DEN_W       = $clog2(CM_TICKS * MAX_PINGS + 1);
  localparam int DVD_W       = TOTAL_W + SCALE_SHIFT + 1;
  localparam int ITER_W      = $clog2(DVD_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 2'd3;

  // Register reset values
  localparam logic [TRIG_W-1:0]    RST_TRIGGER_WIDTH = 10'd20;
  localparam logic [TIMEOUT_W-1:0] RST_ECHO_TIMEOUT  = 16'd60000;
  localparam logic [SETTLE_W-1:0]  RST_SETTLE        = 16'd50000;
  localparam logic [COUNT_W-1:0]   RST_SAMPLE_COUNT  = 4'd5;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_RISE  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

  // Microprogram step addresses
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_WAIT,
    ST_HIGH,
    ST_SETTLE,
    ST_DIV
  } step_t;

  // Branch conditions a control word can test
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_TRIG_END,
    COND_ECHO,
    COND_RISE_TIMEOUT,
    COND_ECHO_LONG,
    COND_SETTLE_END,
    COND_LAST_PING,
    COND_DIV_LAST,
    COND_DIV_FINISH
  } cond_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CNT_INC,
    OP_CNT_CLR,
    OP_PW_SET1,
    OP_PW_INC,
    OP_ACCUM,
    OP_ERR_RISE,
    OP_ERR_LONG,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_DONE
  } op_t;

  // One control word: two tests, three branches (a, else b, else c)
  typedef struct packed {
    logic  consume;
    logic  trig;
    cond_t cond_a;
    cond_t cond_b;
    step_t next_a;
    op_t   op_a;
    step_t next_b;
    op_t   op_b;
    step_t next_c;
    op_t   op_c;
  } uword_t;

  // Control store
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      ST_IDLE:   w = '{1'b1, 1'b0, COND_NEVER, COND_NEVER,
                       ST_IDLE, OP_NONE, ST_IDLE, OP_NONE, ST_IDLE, OP_NONE};
      ST_TRIG:   w = '{1'b1, 1'b1, COND_TRIG_END, COND_NEVER,
                       ST_WAIT, OP_CNT_CLR, ST_TRIG, OP_NONE, ST_TRIG, OP_CNT_INC};
      ST_WAIT:   w = '{1'b1, 1'b0, COND_ECHO, COND_RISE_TIMEOUT,
                       ST_HIGH, OP_PW_SET1, ST_IDLE, OP_ERR_RISE, ST_WAIT, OP_CNT_INC};
      ST_HIGH:   w = '{1'b1, 1'b0, COND_ECHO_LONG, COND_ECHO,
                       ST_IDLE, OP_ERR_LONG, ST_HIGH, OP_PW_INC, ST_SETTLE, OP_ACCUM};
      ST_SETTLE: w = '{1'b1, 1'b0, COND_LAST_PING, COND_SETTLE_END,
                       ST_DIV, OP_DIV_START, ST_TRIG, OP_CNT_CLR, ST_SETTLE, OP_CNT_INC};
      ST_DIV:    w = '{1'b0, 1'b0, COND_DIV_FINISH, COND_DIV_LAST,
                       ST_IDLE, OP_DIV_DONE, ST_DIV, OP_NONE, ST_DIV, OP_DIV_STEP};
      default:   w = '{1'b1, 1'b0, COND_NEVER, COND_NEVER,
                       ST_IDLE, OP_NONE, ST_IDLE, OP_NONE, ST_IDLE, OP_NONE};
    endcase
    return w;
  endfunction

endpackage

### src/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: microcoded sequencer and datapath.
// Depends on uer_pkg for types, constants and the control store.
//
// Usage:
//   Each input item is one microsecond tick (start_req, echo_level); each one
//   gives exactly one result item (trigger level, busy, done, error, distance).
//   A start request while idle begins a measurement: the trigger pin is high
//   for trigger_width_us ticks, the echo rise and high time are timed, then
//   settle_us + 1 settle ticks follow; this repeats sample_count times (0 as 1, over 8 as 8).
//   The result of a tick, but for the final settle tick of a good measurement, is
//   registered and shows in the cycle after the tick is accepted; one tick is taken
//   per cycle while the output is free.  That final settle tick starts the restoring
//   divider for the mean distance, which retires one quotient bit per cycle over a
//   24-bit dividend (the last bit waits for a free output); no tick is taken while it runs.
//   An error (echo never rose, or stayed high too long) ends the measurement
//   on that tick with done set and busy clear.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, drops the
//   pending result and loads the register defaults (20, 60000, 50000, 5).
//   While out_stall holds a pending result, in_stall is raised, so the output
//   register drains and refills in the same cycle once the stall lifts.
//   Configuration writes are taken at any cycle with cfg_we high.
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // tick input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_req,
  input  logic                 in_echo_level,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_trigger_level,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic [ERR_W-1:0]     out_error_code,
  output logic [DIST_W-1:0]    out_distance_eighth_cm,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Condition flags seen by the sequencer
  typedef struct packed {
    logic trig_end;
    logic echo;
    logic rise_timeout;
    logic echo_long;
    logic settle_end;
    logic last_ping;
    logic div_last;
    logic div_finish;
  } cond_flags_t;

  function automatic logic cond_pick(input cond_t c, input cond_flags_t f);
    logic hit;
    unique case (c)
      COND_NEVER:        hit = 1'b0;
      COND_TRIG_END:     hit = f.trig_end;
      COND_ECHO:         hit = f.echo;
      COND_RISE_TIMEOUT: hit = f.rise_timeout;
      COND_ECHO_LONG:    hit = f.echo_long;
      COND_SETTLE_END:   hit = f.settle_end;
      COND_LAST_PING:    hit = f.last_ping;
      COND_DIV_LAST:     hit = f.div_last;
      COND_DIV_FINISH:   hit = f.div_finish;
      default:           hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Configuration registers
  logic [TRIG_W-1:0]    cfg_trig_r;
  logic [TIMEOUT_W-1:0] cfg_timeout_r;
  logic [SETTLE_W-1:0]  cfg_settle_r;
  logic [COUNT_W-1:0]   cfg_count_r;

  // Sequencer and datapath registers
  step_t              step_r, step_nxt;
  logic [TICK_W-1:0]  cnt_r;
  logic [TICK_W-1:0]  pw_r;
  logic [PING_W-1:0]  ping_r;
  logic [TOTAL_W-1:0] wt_r;
  logic [DEN_W-1:0]   rem_r;
  logic [DVD_W-1:0]   quo_r;
  logic [ITER_W-1:0]  iter_r;

  // Output register
  logic              out_valid_r;
  logic              trig_out_r, busy_out_r, done_out_r;
  logic [ERR_W-1:0]  err_out_r;
  logic [DIST_W-1:0] dist_out_r;

  // Combinational signals
  uword_t            uw;
  cond_flags_t       flags;
  op_t               op;
  logic              out_free, fire, start_now, load_out;
  step_t             eff_step;
  logic [TICK_W-1:0] cnt_eff, cnt_inc;
  logic [TRIG_W-1:0] tw_eff;
  logic [PING_W-1:0] wanted;
  logic [DEN_W-1:0]  den;
  logic [DVD_W-1:0]  dividend;
  logic [DEN_W:0]    trial;
  logic              q_bit;
  logic [DEN_W-1:0]  rem_new;
  logic [DVD_W-1:0]  quo_new;
  logic [DIST_W-1:0] q_sat;
  logic              trig_o, busy_o, done_o;
  logic [ERR_W-1:0]  err_o;
  logic [DIST_W-1:0] dist_o;

  // A start tick maps idle onto the trigger step; both take input items
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(uw.consume && out_free);
  assign start_now = (step_r == ST_IDLE) && in_start_req;
  assign eff_step  = start_now ? ST_TRIG : step_r;

  // Register clamps
  assign tw_eff = (cfg_trig_r == '0) ? TRIG_W'(1) : cfg_trig_r;
  always_comb begin
    if (cfg_count_r == '0) begin
      wanted = PING_W'(1);
    end else if (int'(cfg_count_r) > MAX_PINGS) begin
      wanted = PING_W'(MAX_PINGS);
    end else begin
      wanted = PING_W'(cfg_count_r);
    end
  end

  // Divider: denominator 58 * pings, dividend width * 8 + half denominator
  assign den      = DEN_W'({{(DEN_W-PING_W){1'b0}}, ping_r} * DEN_W'(CM_TICKS));
  assign dividend = DVD_W'({wt_r, {SCALE_SHIFT{1'b0}}}) + DVD_W'(den >> 1);
  assign trial    = {rem_r, quo_r[DVD_W-1]};
  assign q_bit    = trial >= {1'b0, den};
  assign rem_new  = q_bit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
  assign quo_new  = {quo_r[DVD_W-2:0], q_bit};
  assign q_sat    = (|quo_new[DVD_W-1:DIST_W]) ? '1 : quo_new[DIST_W-1:0];

  // Counter increment; a start tick counts from zero
  assign cnt_eff = start_now ? '0 : cnt_r;
  assign cnt_inc = cnt_eff + TICK_W'(1);

  // Condition flags
  always_comb begin
    flags.trig_end     = cnt_inc >= TICK_W'(tw_eff);
    flags.echo         = in_echo_level;
    flags.rise_timeout = cnt_inc >= cfg_timeout_r;
    flags.echo_long    = in_echo_level && (pw_r >= cfg_timeout_r);
    flags.settle_end   = cnt_r >= cfg_settle_r;
    flags.last_ping    = flags.settle_end && (ping_r >= wanted);
    flags.div_last     = iter_r == ITER_W'(DVD_W - 1);
    flags.div_finish   = flags.div_last && out_free;
  end

  // Next step and operation from the control word
  always_comb begin
    uw = ucode_rom(eff_step);
    priority if (cond_pick(uw.cond_a, flags)) begin
      step_nxt = uw.next_a;
      op       = uw.op_a;
    end else if (cond_pick(uw.cond_b, flags)) begin
      step_nxt = uw.next_b;
      op       = uw.op_b;
    end else begin
      step_nxt = uw.next_c;
      op       = uw.op_c;
    end
    fire = uw.consume ? (in_valid && out_free) : 1'b1;
  end

  // Result fields for the current step
  always_comb begin
    trig_o   = uw.trig;
    busy_o   = step_nxt != ST_IDLE;
    done_o   = (op == OP_ERR_RISE) || (op == OP_ERR_LONG) || (op == OP_DIV_DONE);
    err_o    = ERR_NONE;
    dist_o   = '0;
    load_out = fire && ((uw.consume && (op != OP_DIV_START)) || (op == OP_DIV_DONE));
    unique case (op)
      OP_ERR_RISE: err_o = ERR_NO_RISE;
      OP_ERR_LONG: err_o = ERR_TOO_LONG;
      OP_DIV_DONE: dist_o = q_sat;
      default:     err_o = ERR_NONE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_trig_r    <= RST_TRIGGER_WIDTH;
      cfg_timeout_r <= RST_ECHO_TIMEOUT;
      cfg_settle_r  <= RST_SETTLE;
      cfg_count_r   <= RST_SAMPLE_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER_WIDTH: cfg_trig_r    <= cfg_wdata[TRIG_W-1:0];
        CFG_ECHO_TIMEOUT:  cfg_timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_SETTLE:        cfg_settle_r  <= cfg_wdata[SETTLE_W-1:0];
        CFG_SAMPLE_COUNT:  cfg_count_r   <= cfg_wdata[COUNT_W-1:0];
        default:           cfg_count_r   <= cfg_count_r;
      endcase
    end
  end

  // Step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else if (fire) begin
      step_r <= step_nxt;
    end
  end

  // Datapath counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ping_r <= '0;
      iter_r <= '0;
    end else if (fire) begin
      if (start_now) begin
        ping_r <= '0;
        wt_r   <= '0;
        pw_r   <= '0;
      end
      unique case (op)
        OP_CNT_INC: cnt_r <= cnt_inc;
        OP_CNT_CLR: cnt_r <= '0;
        OP_PW_SET1: pw_r  <= TICK_W'(1);
        OP_PW_INC:  pw_r  <= pw_r + TICK_W'(1);
        OP_ACCUM: begin
          wt_r   <= wt_r + TOTAL_W'(pw_r);
          ping_r <= ping_r + PING_W'(1);
          cnt_r  <= '0;
        end
        OP_DIV_START: begin
          quo_r  <= dividend;
          rem_r  <= '0;
          iter_r <= '0;
        end
        OP_DIV_STEP: begin
          quo_r  <= quo_new;
          rem_r  <= rem_new;
          iter_r <= iter_r + ITER_W'(1);
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      trig_out_r <= trig_o;
      busy_out_r <= busy_o;
      done_out_r <= done_o;
      err_out_r  <= err_o;
      dist_out_r <= dist_o;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_trigger_level      = trig_out_r;
  assign out_busy_res           = busy_out_r;
  assign out_done_res           = done_out_r;
  assign out_error_code         = err_out_r;
  assign out_distance_eighth_cm = dist_out_r;

endmodule

### src/uer_checker.sv
// Port-level assertions for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg for widths and error codes.
module uer_checker
  import uer_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_start_req,
  input logic                 in_echo_level,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_trigger_level,
  input logic                 out_busy_res,
  input logic                 out_done_res,
  input logic [ERR_W-1:0]     out_error_code,
  input logic [DIST_W-1:0]    out_distance_eighth_cm,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_wdata
);

  // A finished measurement never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done item reports busy");

  // Error code and distance only appear on a done item
  a_quiet_when_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> (out_error_code == ERR_NONE) &&
                                   (out_distance_eighth_cm == '0))
    else $error("error or distance outside a done item");

  // A failed measurement carries no distance and a known code
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |->
      (out_distance_eighth_cm == '0) &&
      ((out_error_code == ERR_NO_RISE) || (out_error_code == ERR_TOO_LONG)))
    else $error("bad error item");

  // Pending result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trigger_level) &&
      $stable(out_busy_res) && $stable(out_done_res) &&
      $stable(out_error_code) && $stable(out_distance_eighth_cm))
    else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ultrasonic_echo_ranger: random tick items feed a tick-level
// predictor of the ranger, and every result item is checked field by field.
// Depends on uer_pkg and ultrasonic_echo_ranger from src.
module tb;
  import uer_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_TICKS  = 80;

  typedef struct packed {
    bit start;
    bit echo;
  } tick_item_t;

  typedef struct {
    bit                 trig;
    bit                 busy;
    bit                 done;
    logic [ERR_W-1:0]   err;
    logic [DIST_W-1:0]  distance;
  } tick_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_start_req = 1'b0;
  logic                 in_echo_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_trigger_level;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [ERR_W-1:0]     out_error_code;
  logic [DIST_W-1:0]    out_distance_eighth_cm;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIGGER_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  ultrasonic_echo_ranger dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_start_req           (in_start_req),
    .in_echo_level          (in_echo_level),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_trigger_level      (out_trigger_level),
    .out_busy_res           (out_busy_res),
    .out_done_res           (out_done_res),
    .out_error_code         (out_error_code),
    .out_distance_eighth_cm (out_distance_eighth_cm),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  // Ticks waiting to be sent, results waiting to be seen
  tick_item_t   tick_queue[$];
  tick_result_t echo_results_due[$];
  int           ticks_queued = 0;
  int           ticks_taken = 0;
  int           results_seen = 0;
  int           fail_count = 0;
  int           cycle_count = 0;

  // Predictor copy of the registers and the sequencer state
  logic [TRIG_W-1:0]    c_trig;
  logic [TIMEOUT_W-1:0] c_timeout;
  logic [SETTLE_W-1:0]  c_settle;
  logic [COUNT_W-1:0]   c_count;
  step_t                rng_phase;
  logic [TICK_W-1:0]    rng_ticks;
  logic [TICK_W-1:0]    rng_width;
  logic [4:0]           rng_pings;
  logic [TOTAL_W-1:0]   rng_total;
  logic [DIST_W-1:0]    rng_dist;

  // Driver and receiver pacing
  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          hold_left = 0;
  int          holds_done = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One microsecond tick of the ranger; updates the predictor state
  function automatic tick_result_t ranger_tick(input bit start, input bit echo);
    tick_result_t r;
    int unsigned  tw, want, den, q;
    r.trig     = 1'b0;
    r.busy     = 1'b0;
    r.done     = 1'b0;
    r.err      = ERR_NONE;
    r.distance = '0;
    tw = (c_trig == 0) ? 1 : c_trig;
    if (rng_phase == ST_IDLE && start) begin
      rng_pings = '0;
      rng_total = '0;
      rng_width = '0;
      rng_ticks = '0;
      rng_phase = ST_TRIG;
    end
    case (rng_phase)
      ST_TRIG: begin
        r.trig = 1'b1;
        rng_ticks = rng_ticks + 1'b1;
        if (rng_ticks >= tw) begin
          rng_phase = ST_WAIT;
          rng_ticks = '0;
        end
      end
      ST_WAIT: begin
        if (echo) begin
          rng_width = 1;
          rng_phase = ST_HIGH;
        end else begin
          rng_ticks = rng_ticks + 1'b1;
          if (rng_ticks >= c_timeout) begin
            r.done = 1'b1;
            r.err = ERR_NO_RISE;
            rng_phase = ST_IDLE;
          end
        end
      end
      ST_HIGH: begin
        if (echo) begin
          if (rng_width >= c_timeout) begin
            r.done = 1'b1;
            r.err = ERR_TOO_LONG;
            rng_phase = ST_IDLE;
          end else begin
            rng_width = rng_width + 1'b1;
          end
        end else begin
          rng_total = rng_total + TOTAL_W'(rng_width);
          rng_pings = rng_pings + 1'b1;
          rng_phase = ST_SETTLE;
          rng_ticks = '0;
        end
      end
      ST_SETTLE: begin
        if (rng_ticks >= c_settle) begin
          want = (c_count == 0) ? 1 : ((c_count > MAX_PINGS) ? MAX_PINGS : c_count);
          if (rng_pings >= want) begin
            // mean width scaled to eighth-cm, halves rounded up
            den = CM_TICKS * ((rng_pings == 0) ? 1 : rng_pings);
            q = ((rng_total << SCALE_SHIFT) + den / 2) / den;
            if (q > (1 << DIST_W) - 1) q = (1 << DIST_W) - 1;
            rng_dist = q[DIST_W-1:0];
            r.done = 1'b1;
            r.distance = rng_dist;
            rng_phase = ST_IDLE;
          end else begin
            rng_phase = ST_TRIG;
            rng_ticks = '0;
          end
        end else begin
          rng_ticks = rng_ticks + 1'b1;
        end
      end
      default: rng_phase = ST_IDLE;
    endcase
    r.busy = (rng_phase != ST_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40)
      $display("tb: mismatch on %s at result %0d: got %0d, want %0d",
               what, results_seen, got, want);
  endtask

  task automatic push_tick(input bit start, input bit echo);
    tick_queue.push_back('{start: start, echo: echo});
    ticks_queued++;
  endtask

  // Hold the sender until every result, the divider's too, is in, then let the bench idle
  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || echo_results_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A full measurement under the current registers; fault picks an error ping
  task automatic queue_measurement(input logic [ERR_W-1:0] fault, input bit full_width);
    int twe, toe, pings, bad_ping, lows, highs, settle_n;
    twe      = (c_trig == 0) ? 1 : c_trig;
    toe      = (c_timeout == 0) ? 1 : c_timeout;
    pings    = (c_count == 0) ? 1 : ((c_count > MAX_PINGS) ? MAX_PINGS : c_count);
    settle_n = c_settle;
    bad_ping = $urandom_range(0, pings - 1);
    push_tick(1'b1, $urandom_range(0, 1));
    for (int p = 0; p < pings; p++) begin
      repeat ((p == 0) ? twe - 1 : twe) push_tick($urandom_range(0, 1), $urandom_range(0, 1));
      if (fault == ERR_NO_RISE && p == bad_ping) begin
        repeat (toe) push_tick($urandom_range(0, 1), 1'b0);
        return;
      end
      lows = $urandom_range(0, (toe - 1 < 12) ? toe - 1 : 12);
      repeat (lows) push_tick($urandom_range(0, 1), 1'b0);
      if (fault == ERR_TOO_LONG && p == bad_ping) begin
        repeat (toe + 1) push_tick($urandom_range(0, 1), 1'b1);
        return;
      end
      highs = full_width ? toe : $urandom_range(1, (toe < 40) ? toe : 40);
      repeat (highs) push_tick($urandom_range(0, 1), 1'b1);
      push_tick($urandom_range(0, 1), 1'b0);
      repeat (settle_n + 1) push_tick($urandom_range(0, 1), $urandom_range(0, 1));
    end
  endtask

  // Stimulus
  initial begin
    int start_n, pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: start and a few trigger ticks, start while busy ignored
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    wait_drained();

    // rewrite mid-measurement: trigger ends, ping, second ping, rise timeout
    cfg_write(CFG_TRIGGER_WIDTH, 16'd2);
    cfg_write(CFG_ECHO_TIMEOUT, 16'd3);
    cfg_write(CFG_SETTLE, 16'd1);
    cfg_write(CFG_SAMPLE_COUNT, 16'd2);
    @(negedge clk);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    repeat (3) push_tick(1'b0, 1'b0);
    wait_drained();

    // zero registers: width, timeout and count act as one; settle of zero
    cfg_write(CFG_TRIGGER_WIDTH, 16'hFC00);
    cfg_write(CFG_ECHO_TIMEOUT, 16'd0);
    cfg_write(CFG_SETTLE, 16'd0);
    cfg_write(CFG_SAMPLE_COUNT, 16'hFFF0);
    @(negedge clk);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);
    wait_drained();

    // random phases: mostly clean measurements, some faults and noise
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_TRIGGER_WIDTH, (16'($urandom) & 16'hFC00) | 16'($urandom_range(0, 4)));
      cfg_write(CFG_ECHO_TIMEOUT,
                16'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20)));
      cfg_write(CFG_SETTLE, 16'($urandom_range(0, 6)));
      cfg_write(CFG_SAMPLE_COUNT, (16'($urandom) & 16'hFFF0) | 16'($urandom_range(0, 15)));
      @(negedge clk);
      start_n = ticks_queued;
      while (ticks_queued - start_n < PHASE_TICKS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          repeat ($urandom_range(1, 8)) push_tick($urandom_range(0, 1), $urandom_range(0, 1));
        else if (pick == 1)
          queue_measurement(ERR_NO_RISE, 1'b0);
        else if (pick == 2)
          queue_measurement(ERR_TOO_LONG, 1'b0);
        else
          queue_measurement(ERR_NONE, pick == 3);
        repeat ($urandom_range(0, 3)) push_tick(1'b0, $urandom_range(0, 1));
      end
      wait_drained();
    end

    // noise may leave a measurement open; run it out with quiet ticks
    while (rng_phase != ST_IDLE) begin
      @(negedge clk);
      push_tick(1'b0, 1'b0);
      wait_drained();
    end

    // full-scale timeout, echo well inside it
    cfg_write(CFG_TRIGGER_WIDTH, 16'hFC03);
    cfg_write(CFG_ECHO_TIMEOUT, 16'hFFFF);
    cfg_write(CFG_SETTLE, 16'd0);
    cfg_write(CFG_SAMPLE_COUNT, 16'd1);
    @(negedge clk);
    queue_measurement(ERR_NONE, 1'b0);
    wait_drained();

    // longer settle
    cfg_write(CFG_TRIGGER_WIDTH, 16'hFC01);
    cfg_write(CFG_ECHO_TIMEOUT, 16'd1);
    cfg_write(CFG_SETTLE, 16'd40);
    @(negedge clk);
    queue_measurement(ERR_NONE, 1'b0);
    wait_drained();

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Driver: bursts of items with random gaps; a stalled item is held
  always @(posedge clk) begin
    tick_item_t it;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 50);
      gap_left   = 0;
    end else if (in_valid && in_stall) begin
      // keep the item on the port
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (tick_queue.size() != 0) begin
      it = tick_queue.pop_front();
      in_valid      <= 1'b1;
      in_start_req  <= it.start;
      in_echo_level <= it.echo;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 50);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern, with a long hold-off on top
  always @(posedge clk) begin
    bit pattern_stall;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      stall_mode = STALL_NONE;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_LIGHT:    pattern_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    pattern_stall = ($urandom_range(0, 1) == 0);
        STALL_PERIODIC: pattern_stall = (stall_left % 5 < 2);
        default:        pattern_stall = 1'b0;
      endcase
      out_stall <= (hold_left != 0) || pattern_stall;
    end
  end

  // Two long hold-offs while the sender keeps offering ticks
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && ticks_taken >= 300 * (holds_done + 1)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: check each result item, then predict for each accepted tick
  always @(posedge clk) begin
    tick_result_t due;
    if (!rst_n) begin
      c_trig    = RST_TRIGGER_WIDTH;
      c_timeout = RST_ECHO_TIMEOUT;
      c_settle  = RST_SETTLE;
      c_count   = RST_SAMPLE_COUNT;
      rng_phase = ST_IDLE;
      rng_ticks = '0;
      rng_width = '0;
      rng_pings = '0;
      rng_total = '0;
      rng_dist  = '0;
      echo_results_due.delete();
      ticks_taken <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (echo_results_due.size() == 0) begin
          report_mismatch("result with no tick pending", 1, 0);
        end else begin
          due = echo_results_due.pop_front();
          if (out_trigger_level !== due.trig)
            report_mismatch("trigger_level", out_trigger_level, due.trig);
          if (out_busy_res !== due.busy)
            report_mismatch("busy_res", out_busy_res, due.busy);
          if (out_done_res !== due.done)
            report_mismatch("done_res", out_done_res, due.done);
          if (out_error_code !== due.err)
            report_mismatch("error_code", out_error_code, due.err);
          if (out_distance_eighth_cm !== due.distance)
            report_mismatch("distance_eighth_cm", out_distance_eighth_cm, due.distance);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_WIDTH: c_trig    = cfg_wdata[TRIG_W-1:0];
          CFG_ECHO_TIMEOUT:  c_timeout = cfg_wdata[TIMEOUT_W-1:0];
          CFG_SETTLE:        c_settle  = cfg_wdata[SETTLE_W-1:0];
          CFG_SAMPLE_COUNT:  c_count   = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        echo_results_due.push_back(ranger_tick(in_start_req, in_echo_level));
        ticks_taken <= ticks_taken + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
